@@ design/vector3_arithmetic_unit_top_defines.svh @@
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit_top_defines
// Assertion macros shared by the vector arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define VECTOR3_ARITHMETIC_UNIT_TOP_DEFINES_SVH
// Property checked on every rising clock edge outside reset.
`define V3A_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// A result that waits under a stall keeps the given output unchanged.
`define V3A_ASSERT_HELD(label, sig) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (out_valid && out_stall |=> $stable(sig))) else $error("output changed under stall");
`endif

@@ design/v3au_pkg.sv @@
// ----------------------------------------------------------------------------
// v3au_pkg
// Shared constants and types of the 3D vector arithmetic unit.
// ----------------------------------------------------------------------------
package v3au_pkg;
  localparam int FracBitsDefault = 16;
  localparam logic [2:0] CmdAdd = 3'd0;
  localparam logic [2:0] CmdSub = 3'd1;
  localparam logic [2:0] CmdScale = 3'd2;
  localparam logic [2:0] CmdDiv = 3'd3;
  localparam logic [2:0] CmdCross = 3'd4;
  localparam logic [2:0] CmdLength = 3'd5;
  localparam logic [2:0] CmdNorm = 3'd6;
  localparam logic [2:0] CmdSpare = 3'd7;
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StDiv0 = 2'd1;
  localparam logic [1:0] StOvf = 2'd2;
endpackage

@@ design/vector3_arithmetic_unit_top.sv @@
// Vector arithmetic unit: one transaction in per cycle unless the output is stalled, one result per
// transaction. Every command travels the same 68 register stages: products,
// combined terms, a 32-stage square-root pipeline (one root bit per stage),
// divider setup, a 32-stage restoring divider (one quotient bit per stage) and
// the output register. A stalled result freezes the whole pipeline and holds
// in_stall high until it is taken.
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit_top
// Signed fixed-point 3D vector ALU: add, subtract, scale, divide, cross,
// length and normalize, with saturation and status.
// ----------------------------------------------------------------------------
`include "vector3_arithmetic_unit_top_defines.svh"
module vector3_arithmetic_unit_top #(
  parameter int FRAC_BITS = v3au_pkg::FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         command,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] az,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by,
  input  logic signed [31:0] bz,
  input  logic signed [31:0] scalar,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] rx,
  output logic signed [31:0] ry,
  output logic signed [31:0] rz,
  output logic [1:0]         status
);
  localparam int SQ = 32;          // square-root stages (one result bit each)
  localparam int NQ = 32;          // divider stages (one quotient bit each)
  localparam int S1 = 1;           // stage holding the combined terms
  localparam int SR = S1 + SQ;     // stage holding the finished root
  localparam int SD = SR + 1;      // first divider stage
  localparam int SF = SD + NQ;     // stage holding the finished quotients
  localparam int LAT = SF + 2;     // total stages

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] a0, a1, a2;
    logic signed [31:0] sc;
  } ctl_t;

  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Valid and control pipelines.
  logic [LAT-1:0] vld;
  ctl_t ctl [SF+1];
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl[0] <= '{command, ax, ay, az, scalar};
      for (int k = 1; k <= SF; k++) ctl[k] <= ctl[k-1];
    end
  end

  // Stage 0: products, sums and differences.
  logic signed [63:0] p [9];
  logic signed [63:0] ps [3];
  logic signed [32:0] sm [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      p[0] <= ay * bz; p[1] <= az * by;
      p[2] <= az * bx; p[3] <= ax * bz;
      p[4] <= ax * by; p[5] <= ay * bx;
      p[6] <= ax * ax; p[7] <= ay * ay;
      p[8] <= az * az;
      ps[0] <= ax * scalar; ps[1] <= ay * scalar; ps[2] <= az * scalar;
      if (command == v3au_pkg::CmdSub) begin
        sm[0] <= 33'(ax) - 33'(bx);
        sm[1] <= 33'(ay) - 33'(by);
        sm[2] <= 33'(az) - 33'(bz);
      end else begin
        sm[0] <= 33'(ax) + 33'(bx);
        sm[1] <= 33'(ay) + 33'(by);
        sm[2] <= 33'(az) + 33'(bz);
      end
    end
  end

  // Stage 1: cross differences or the per-command term; sum of squares.
  logic signed [65:0] w [3];
  logic [65:0] ssq;
  always_ff @(posedge clk) begin
    if (adv) begin
      if (ctl[0].cmd == v3au_pkg::CmdCross) begin
        w[0] <= 66'(p[0]) - 66'(p[1]);
        w[1] <= 66'(p[2]) - 66'(p[3]);
        w[2] <= 66'(p[4]) - 66'(p[5]);
      end else if (ctl[0].cmd == v3au_pkg::CmdScale) begin
        for (int c = 0; c < 3; c++) w[c] <= 66'(ps[c]);
      end else begin
        for (int c = 0; c < 3; c++) w[c] <= 66'(sm[c]);
      end
      ssq <= 66'($unsigned(p[6])) + 66'($unsigned(p[7])) + 66'($unsigned(p[8]));
    end
  end

  // Square root pipeline: one result bit per stage.
  logic [65:0] sq_rem [SQ+1];
  logic [32:0] sq_root [SQ+1];
  logic signed [65:0] w_d [SQ+1][3];
  assign sq_rem[0] = ssq;
  assign sq_root[0] = '0;
  assign w_d[0] = w;
  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    localparam int SH = 2 * (SQ - 1 - g);
    logic [65:0] trial;
    logic [65:0] rem_q;
    logic [32:0] root_q;
    logic signed [65:0] w_q [3];
    assign trial = ({33'd0, sq_root[g]} << (SH + 2)) | (66'd1 << SH);
    always_ff @(posedge clk) begin
      if (adv) begin
        if (sq_rem[g] >= trial) begin
          rem_q <= sq_rem[g] - trial;
          root_q <= {sq_root[g][31:0], 1'b1};
        end else begin
          rem_q <= sq_rem[g];
          root_q <= {sq_root[g][31:0], 1'b0};
        end
        w_q <= w_d[g];
      end
    end
    assign sq_rem[g+1] = rem_q;
    assign sq_root[g+1] = root_q;
    assign w_d[g+1] = w_q;
  end

  // Round the root to nearest and set up the divider operands.
  ctl_t cs;
  assign cs = ctl[SR];
  logic [32:0] len_c;
  assign len_c = sq_root[SQ] + 33'(sq_rem[SQ] > 66'(sq_root[SQ]));
  logic [32:0] sc_ext, ud_c;
  logic [33:0] dv_c;
  assign sc_ext = {cs.sc[31], cs.sc};
  assign ud_c = (cs.cmd == v3au_pkg::CmdNorm) ? len_c
              : (cs.sc[31] ? -sc_ext : sc_ext);
  assign dv_c = {ud_c, 1'b0};

  // Each component gets its own divider lane. A quotient of 2^32 or more
  // is flagged up front and only the low 32 quotient bits are developed.
  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] q;
    logic        neg;
    logic        big;
  } lane_t;
  lane_t ln [NQ+1][3];
  for (genvar c = 0; c < 3; c++) begin : g_lane_in
    logic signed [31:0] av;
    logic [31:0] mag;
    logic [63:0] num;
    lane_t q0;
    assign av = (c == 0) ? cs.a0 : (c == 1) ? cs.a1 : cs.a2;
    assign mag = av[31] ? 32'(-av) : 32'(av);
    // 2*|a|*2^F + |den| over 2*|den| rounds half away from zero.
    assign num = (64'(mag) << (FRAC_BITS + 1)) + 64'(ud_c);
    always_ff @(posedge clk) begin
      if (adv) begin
        q0.rem <= {3'd0, num[63:32]};
        q0.q <= num[31:0];
        q0.neg <= av[31] ^ ((cs.cmd == v3au_pkg::CmdDiv) && cs.sc[31]);
        q0.big <= ({2'd0, num[63:32]} >= dv_c);
      end
    end
    assign ln[0][c] = q0;
  end

  // Divisor, length and the rounded-shift terms travel beside the lanes.
  logic [33:0] dv_d [NQ+1];
  logic [32:0] len_d [NQ+1];
  logic signed [65:0] wr [NQ+1][3];
  logic [33:0] dv0;
  logic [32:0] len0;
  logic signed [65:0] w0 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      dv0 <= dv_c;
      len0 <= len_c;
      w0 <= w_d[SQ];
    end
  end
  assign dv_d[0] = dv0;
  assign len_d[0] = len0;
  assign wr[0] = w0;
  for (genvar g = 0; g < NQ; g++) begin : g_div
    logic [33:0] dreg;
    logic [32:0] lreg;
    logic signed [65:0] t [3];
    always_ff @(posedge clk) begin
      if (adv) begin
        dreg <= dv_d[g];
        lreg <= len_d[g];
        t <= wr[g];
      end
    end
    assign dv_d[g+1] = dreg;
    assign len_d[g+1] = lreg;
    assign wr[g+1] = t;
    for (genvar c = 0; c < 3; c++) begin : g_l
      logic [34:0] sh;
      lane_t r;
      assign sh = {ln[g][c].rem[33:0], ln[g][c].q[31]};
      always_ff @(posedge clk) begin
        if (adv) begin
          r.neg <= ln[g][c].neg;
          r.big <= ln[g][c].big;
          if (sh >= 35'(dv_d[g])) begin
            r.rem <= sh - 35'(dv_d[g]);
            r.q <= {ln[g][c].q[30:0], 1'b1};
          end else begin
            r.rem <= sh;
            r.q <= {ln[g][c].q[30:0], 1'b0};
          end
        end
      end
      assign ln[g+1][c] = r;
    end
  end

  // Final stage: select, saturate, status.
  ctl_t cf;
  assign cf = ctl[SF];
  logic [66:0] mq [3];
  logic signed [66:0] v [3];
  logic signed [31:0] o [3];
  logic ovf;
  logic [1:0] st;
  always_comb begin
    ovf = 1'b0;
    st = v3au_pkg::StOk;
    for (int c = 0; c < 3; c++) begin
      mq[c] = ln[NQ][c].big ? (67'd1 << 32) : 67'(ln[NQ][c].q);
      case (cf.cmd) inside
        v3au_pkg::CmdAdd, v3au_pkg::CmdSub: v[c] = 67'(wr[NQ][c]);
        v3au_pkg::CmdScale, v3au_pkg::CmdCross:
          v[c] = 67'((wr[NQ][c] + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        v3au_pkg::CmdDiv, v3au_pkg::CmdNorm:
          v[c] = ln[NQ][c].neg ? -$signed(mq[c]) : $signed(mq[c]);
        v3au_pkg::CmdLength: v[c] = (c == 0) ? $signed(67'(len_d[NQ])) : '0;
        default: v[c] = '0;
      endcase
      if (v[c] > 67'sd2147483647) begin
        o[c] = 32'sh7fffffff; ovf = 1'b1;
      end else if (v[c] < -67'sd2147483648) begin
        o[c] = 32'sh80000000; ovf = 1'b1;
      end else begin
        o[c] = 32'(v[c]);
      end
    end
    if ((cf.cmd == v3au_pkg::CmdDiv || cf.cmd == v3au_pkg::CmdNorm)
        && dv_d[NQ] == '0) begin
      st = v3au_pkg::StDiv0;
      for (int c = 0; c < 3; c++) o[c] = '0;
    end else if (ovf) begin
      st = v3au_pkg::StOvf;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      rx <= o[0]; ry <= o[1]; rz <= o[2]; status <= st;
    end
  end
  assign out_valid = vld[LAT-1];

  logic out_div0;
  assign out_div0 = (status == v3au_pkg::StDiv0);

  `V3A_ASSERT(a_stall_keep, out_valid && out_stall |=> out_valid, "result lost under stall")
  `V3A_ASSERT_HELD(a_rx_held, rx)
  `V3A_ASSERT_HELD(a_status_held, status)
  `V3A_ASSERT(a_st_range, out_valid |-> status <= v3au_pkg::StOvf, "bad status code")
  `V3A_ASSERT(a_div0_zero, out_valid && out_div0 |-> (rx | ry | rz) == '0, "div0 nonzero")
endmodule

@@ dv/tb_vector3_arithmetic_unit_top.sv @@
// ----------------------------------------------------------------------------
// tb_vector3_arithmetic_unit_top
// Self-checking testbench for the 3D vector arithmetic unit. Directed corner
// transactions and random transactions are sent under several idling phases;
// each result is compared field by field with a built-in fixed-point model.
// ----------------------------------------------------------------------------
module tb_vector3_arithmetic_unit_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Frac = v3au_pkg::FracBitsDefault;
  localparam int NumRandom = 1530;

  typedef struct {
    logic [2:0] cmd;
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic signed [31:0] s;
  } vec_op_t;

  typedef struct {
    logic signed [31:0] r [3];
    logic [1:0] st;
  } vec_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] command = '0;
  logic signed [31:0] ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0;
  logic signed [31:0] scalar = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] rx, ry, rz;
  logic [1:0] status;

  vec_op_t pending_ops [$];
  vec_res_t expected_results [$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit failed = 1'b0;

  vector3_arithmetic_unit_top u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
    .scalar(scalar), .out_valid(out_valid), .out_stall(out_stall),
    .rx(rx), .ry(ry), .rz(rz), .status(status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Clamp to 32 bits and flag an overflow.
  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                 inout bit ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Round half up, then drop the fraction bits (arithmetic shift is floor).
  function automatic logic signed [127:0] round_frac(input logic signed [127:0] v);
    return (v + (128'sd1 <<< (Frac - 1))) >>> Frac;
  endfunction

  // Quotient rounded to nearest, ties away from zero.
  function automatic logic signed [127:0] div_nearest(input logic signed [127:0] n,
                                                      input logic signed [127:0] d);
    logic [127:0] un, ud, q;
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    q = (2 * un + ud) / (2 * ud);
    return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
  endfunction

  // Rounded Euclidean length of a vector.
  function automatic logic [63:0] vec_length(input logic signed [31:0] v [3]);
    logic [65:0] sum, r, bitv;
    logic signed [65:0] t;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      t = v[i];
      sum += 66'(t * t);
    end
    r = 0;
    bitv = 66'd1 << 64;
    while (bitv > sum) bitv >>= 2;
    while (bitv != 0) begin
      if (sum >= r + bitv) begin
        sum -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    if (sum > r) r++;
    return r[63:0];
  endfunction

  // Expected result of one vector operation.
  function automatic vec_res_t compute_vector_op(input vec_op_t op);
    vec_res_t res;
    bit ovf;
    logic signed [127:0] a [3], b [3], s, len;
    ovf = 1'b0;
    res.st = v3au_pkg::StOk;
    for (int i = 0; i < 3; i++) begin
      res.r[i] = 0;
      a[i] = op.a[i];
      b[i] = op.b[i];
    end
    s = op.s;
    case (op.cmd)
      v3au_pkg::CmdAdd:
        for (int i = 0; i < 3; i++) res.r[i] = clamp32(a[i] + b[i], ovf);
      v3au_pkg::CmdSub:
        for (int i = 0; i < 3; i++) res.r[i] = clamp32(a[i] - b[i], ovf);
      v3au_pkg::CmdScale:
        for (int i = 0; i < 3; i++) res.r[i] = clamp32(round_frac(a[i] * s), ovf);
      v3au_pkg::CmdDiv: begin
        if (s == 0) res.st = v3au_pkg::StDiv0;
        else for (int i = 0; i < 3; i++)
          res.r[i] = clamp32(div_nearest(a[i] <<< Frac, s), ovf);
      end
      v3au_pkg::CmdCross: begin
        res.r[0] = clamp32(round_frac(a[1] * b[2] - a[2] * b[1]), ovf);
        res.r[1] = clamp32(round_frac(a[2] * b[0] - a[0] * b[2]), ovf);
        res.r[2] = clamp32(round_frac(a[0] * b[1] - a[1] * b[0]), ovf);
      end
      v3au_pkg::CmdLength: begin
        len = {64'd0, vec_length(op.a)};
        res.r[0] = clamp32(len, ovf);
      end
      v3au_pkg::CmdNorm: begin
        len = {64'd0, vec_length(op.a)};
        if (len == 0) res.st = v3au_pkg::StDiv0;
        else for (int i = 0; i < 3; i++)
          res.r[i] = clamp32(div_nearest(a[i] <<< Frac, len), ovf);
      end
      default: ;
    endcase
    if (ovf && res.st == v3au_pkg::StOk) res.st = v3au_pkg::StOvf;
    return res;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      4: return $signed($urandom_range(0, 32'h3fffff)) - 32'sh200000;
      default: return $urandom;
    endcase
  endfunction

  function automatic vec_op_t make_op(input logic [2:0] cmd, input logic signed [31:0] av,
                                      input logic signed [31:0] bv,
                                      input logic signed [31:0] sv);
    vec_op_t op;
    op.cmd = cmd;
    for (int i = 0; i < 3; i++) begin
      op.a[i] = av;
      op.b[i] = bv;
    end
    op.s = sv;
    return op;
  endfunction

  // Driver: present the next pending transaction, hold it while stalled.
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          vec_op_t op;
          op = pending_ops.pop_front();
          expected_results.push_back(compute_vector_op(op));
          in_valid <= 1'b1;
          command <= op.cmd;
          ax <= op.a[0]; ay <= op.a[1]; az <= op.a[2];
          bx <= op.b[0]; by <= op.b[1]; bz <= op.b[2];
          scalar <= op.s;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result rx=%0d", rx);
        failed = 1'b1;
      end else begin
        vec_res_t e;
        e = expected_results.pop_front();
        if (rx !== e.r[0]) begin $error("rx exp %0d got %0d", e.r[0], rx); failed = 1'b1; end
        if (ry !== e.r[1]) begin $error("ry exp %0d got %0d", e.r[1], ry); failed = 1'b1; end
        if (rz !== e.r[2]) begin $error("rz exp %0d got %0d", e.r[2], rz); failed = 1'b1; end
        if (status !== e.st) begin
          $error("status exp %0d got %0d", e.st, status);
          failed = 1'b1;
        end
      end
    end
  end

  // Stimulus and end of test.
  initial begin
    vec_op_t op;
    int total;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // Directed corners: every command, extremes, divide by zero, zero normalize.
    for (int c = 0; c < 8; c++)
      pending_ops.push_back(make_op(3'(c), 32'sh00030000, 32'sh00010000, 32'sh00020000));
    pending_ops.push_back(make_op(v3au_pkg::CmdAdd, 32'sh7fffffff, 32'sh7fffffff, 0));
    pending_ops.push_back(make_op(v3au_pkg::CmdSub, 32'sh80000000, 32'sh7fffffff, 0));
    pending_ops.push_back(make_op(v3au_pkg::CmdScale, 32'sh80000000, 0, 32'sh80000000));
    pending_ops.push_back(make_op(v3au_pkg::CmdScale, 32'sh7fffffff, 0, 32'sh00008000));
    pending_ops.push_back(make_op(v3au_pkg::CmdDiv, 32'sh00010000, 0, 0));
    pending_ops.push_back(make_op(v3au_pkg::CmdDiv, 32'sh80000000, 0, 32'shffffffff));
    pending_ops.push_back(make_op(v3au_pkg::CmdDiv, 32'sh7fffffff, 0, 32'sh80000000));
    pending_ops.push_back(make_op(v3au_pkg::CmdCross, 32'sh80000000, 32'sh7fffffff, 0));
    pending_ops.push_back(make_op(v3au_pkg::CmdLength, 32'sh80000000, 0, 0));
    pending_ops.push_back(make_op(v3au_pkg::CmdLength, 0, 0, 0));
    pending_ops.push_back(make_op(v3au_pkg::CmdNorm, 0, 0, 0));
    pending_ops.push_back(make_op(v3au_pkg::CmdNorm, 32'sh80000000, 0, 0));
    pending_ops.push_back(make_op(v3au_pkg::CmdNorm, 1, 0, 0));
    for (int n = 0; n < NumRandom; n++) begin
      op.cmd = $urandom_range(0, 15) == 0 ? v3au_pkg::CmdSpare : 3'($urandom_range(0, 6));
      for (int i = 0; i < 3; i++) begin
        op.a[i] = pick_value();
        op.b[i] = pick_value();
      end
      op.s = pick_value();
      pending_ops.push_back(op);
    end
    total = pending_ops.size();
    // Idling phases, each covering a quarter of the queue.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 84; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 84; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      wait (pending_ops.size() <= total - (total * (ph + 1)) / 4);
    end
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (!failed && expected_results.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #(12ns * 600000);
    $display("tb: failure");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+design
design/v3au_pkg.sv
design/vector3_arithmetic_unit_top.sv
dv/tb_vector3_arithmetic_unit_top.sv
